// ===== rtl/core/r2y_pkg.sv =====
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0 converter.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package r2y_pkg;

  // Field and register widths.
  localparam int PIX_W    = 8;
  localparam int SUM_W    = PIX_W + 1;
  localparam int LINE_W   = 3 * SUM_W;
  localparam int CFG_W    = 13;
  localparam int ROW_W    = 12;
  localparam int TERM_W   = 17;
  localparam int REG_IDX_W = 1;

  // Frame size limits and reset values.
  localparam int DEFAULT_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // BT.601 coefficients, scaled by 256.
  localparam logic [PIX_W-1:0] K_Y_R  = 8'd66;
  localparam logic [PIX_W-1:0] K_Y_G  = 8'd129;
  localparam logic [PIX_W-1:0] K_Y_B  = 8'd25;
  localparam logic [PIX_W-1:0] K_CB_R = 8'd38;
  localparam logic [PIX_W-1:0] K_CB_G = 8'd74;
  localparam logic [PIX_W-1:0] K_C_MAIN = 8'd112;
  localparam logic [PIX_W-1:0] K_CR_G = 8'd94;
  localparam logic [PIX_W-1:0] K_CR_B = 8'd18;

  localparam logic [TERM_W-1:0] ROUND_HALF     = 17'd128;
  localparam logic [PIX_W-1:0]  LUMA_OFFSET    = 8'd16;
  localparam logic [PIX_W-1:0]  CHROMA_OFFSET  = 8'd128;
  localparam logic [PIX_W-1:0]  NEUTRAL_CHROMA = 8'd128;

  // Horizontal pair sums of one even-row pixel pair, as kept in the line buffer.
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pair_sum_t;

  // Per-pixel control derived from the raster position.
  typedef struct packed {
    logic line_wr;
    logic chroma_valid;
    logic frame_last;
  } pix_ctl_t;

  // Positive and negative product sums of both chroma outputs.
  typedef struct packed {
    logic [TERM_W-1:0] pos_b;
    logic [TERM_W-1:0] neg_b;
    logic [TERM_W-1:0] pos_r;
    logic [TERM_W-1:0] neg_r;
  } chroma_terms_t;

  // Rounded scale by 1/256 plus an offset; the offset keeps the sum non-negative.
  function automatic logic [PIX_W-1:0] scale_down(input logic [TERM_W-1:0] pos,
                                                  input logic [TERM_W-1:0] neg,
                                                  input logic [PIX_W-1:0]  off);
    logic [TERM_W-1:0] t;
    t = pos + ROUND_HALF + {1'b0, off, 8'd0} - neg;
    return t[15:8];
  endfunction

  // Studio-range luma of one pixel.
  function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [TERM_W-1:0] pos;
    pos = TERM_W'(K_Y_R) * TERM_W'(r) + TERM_W'(K_Y_G) * TERM_W'(g)
        + TERM_W'(K_Y_B) * TERM_W'(b);
    return scale_down(pos, '0, LUMA_OFFSET);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/r2y_line_buf.sv =====
// Line buffer holding the even-row pair sums of one line.
// Depends on r2y_pkg for the entry width.
`default_nettype none

module r2y_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [ADDR_W-1:0]         wr_addr,
  input  wire  [r2y_pkg::LINE_W-1:0] wr_data,
  input  wire                       rd_en,
  input  wire  [ADDR_W-1:0]         rd_addr,
  output logic [r2y_pkg::LINE_W-1:0] rd_data_r
);
  import r2y_pkg::*;

  logic [LINE_W-1:0] line_mem_r [DEPTH];

  // Synchronous write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[wr_addr] <= wr_data;
    end
  end

  // Synchronous read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/r2y_raster.sv =====
// Raster position tracking, size registers, left-pixel hold and pair sums.
// Depends on r2y_pkg for widths, register indexes and shared types.
`default_nettype none

module r2y_raster #(
  parameter int MAX_WIDTH  = 4096,
  parameter int COL_W      = 12,
  parameter int ADDR_W     = 11,
  parameter int LINE_SLOTS = 2048
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [r2y_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire  [r2y_pkg::CFG_W-1:0]     cfg_data,
  input  wire                          advance,
  input  wire  [r2y_pkg::PIX_W-1:0]     red,
  input  wire  [r2y_pkg::PIX_W-1:0]     green,
  input  wire  [r2y_pkg::PIX_W-1:0]     blue,
  output logic [ADDR_W-1:0]            slot,
  output r2y_pkg::pair_sum_t           pair_sum,
  output r2y_pkg::pix_ctl_t            ctl
);
  import r2y_pkg::*;

  localparam int CMP_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int RCMP_W = CFG_W + 1;

  logic [CFG_W-1:0]  width_r, height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PIX_W-1:0]  hold_red_r, hold_green_r, hold_blue_r;
  logic [CMP_W-1:0]  width_ext, width_m1;
  logic [RCMP_W-1:0] height_ext, height_m1;
  logic              line_end, frame_end, slot_ok;

  // Size registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes minus one, clamped to the supported range.
  always_comb begin
    width_ext  = CMP_W'(width_r);
    height_ext = RCMP_W'(height_r);
    if (width_ext < CMP_W'(2)) begin
      width_m1 = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_m1 = CMP_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = width_ext - CMP_W'(1);
    end
    if (height_ext < RCMP_W'(2)) begin
      height_m1 = RCMP_W'(1);
    end else if (height_ext > RCMP_W'(HEIGHT_LIMIT)) begin
      height_m1 = RCMP_W'(HEIGHT_LIMIT - 1);
    end else begin
      height_m1 = height_ext - RCMP_W'(1);
    end
  end

  // Line and frame end tests; a position at or past the end closes the line.
  assign line_end  = CMP_W'(col_r) >= width_m1;
  assign frame_end = line_end && (RCMP_W'(row_r) >= height_m1);

  // Next raster position.
  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (line_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Even-column pixel is held for the pair sum of the odd column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_red_r   <= '0;
      hold_green_r <= '0;
      hold_blue_r  <= '0;
    end else if (advance && !col_r[0]) begin
      hold_red_r   <= red;
      hold_green_r <= green;
      hold_blue_r  <= blue;
    end
  end

  // Horizontal pair sums and line buffer slot of the current pixel.
  assign pair_sum.red   = SUM_W'(hold_red_r) + SUM_W'(red);
  assign pair_sum.green = SUM_W'(hold_green_r) + SUM_W'(green);
  assign pair_sum.blue  = SUM_W'(hold_blue_r) + SUM_W'(blue);
  assign slot    = ADDR_W'(col_r >> 1);
  assign slot_ok = (32'(col_r >> 1) < 32'(LINE_SLOTS));

  // Even rows store pair sums; odd rows complete a block on odd columns.
  assign ctl.line_wr      = col_r[0] && !row_r[0] && slot_ok;
  assign ctl.chroma_valid = col_r[0] && row_r[0];
  assign ctl.frame_last   = frame_end;

endmodule

`default_nettype wire

// ===== rtl/core/r2y_chroma.sv =====
// Chroma product stage: 2x2 averages and the BT.601 Cb/Cr products.
// Depends on r2y_pkg for coefficients and the pair sum and term types.
`default_nettype none

module r2y_chroma (
  input  wire                      clk,
  input  wire                      load,
  input  r2y_pkg::pair_sum_t       above,
  input  r2y_pkg::pair_sum_t       below,
  output r2y_pkg::chroma_terms_t   terms_r
);
  import r2y_pkg::*;

  logic [SUM_W:0]    tot_red, tot_green, tot_blue;
  logic [PIX_W-1:0]  avg_red, avg_green, avg_blue;
  chroma_terms_t     terms_nxt;

  // Floored averages of the four pixels of the block.
  always_comb begin
    tot_red   = (SUM_W + 1)'(above.red)   + (SUM_W + 1)'(below.red);
    tot_green = (SUM_W + 1)'(above.green) + (SUM_W + 1)'(below.green);
    tot_blue  = (SUM_W + 1)'(above.blue)  + (SUM_W + 1)'(below.blue);
    avg_red   = tot_red[SUM_W:2];
    avg_green = tot_green[SUM_W:2];
    avg_blue  = tot_blue[SUM_W:2];
  end

  // Constant products, split into positive and negative parts.
  always_comb begin
    terms_nxt.pos_b = TERM_W'(K_C_MAIN) * TERM_W'(avg_blue);
    terms_nxt.neg_b = TERM_W'(K_CB_R) * TERM_W'(avg_red)
                    + TERM_W'(K_CB_G) * TERM_W'(avg_green);
    terms_nxt.pos_r = TERM_W'(K_C_MAIN) * TERM_W'(avg_red);
    terms_nxt.neg_r = TERM_W'(K_CR_G) * TERM_W'(avg_green)
                    + TERM_W'(K_CR_B) * TERM_W'(avg_blue);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_yuv420_converter.sv =====
// Top level of the BT.601 RGB to YUV 4:2:0 pixel stream converter.
// Depends on r2y_pkg, r2y_raster, r2y_line_buf and r2y_chroma.
//
// Usage:
//   RGB pixels enter in raster order on the in_ valid/ready channel, one
//   transaction per pixel. Every pixel gives one out_ transaction with its
//   luma; the lower-right pixel of each complete 2x2 block also carries
//   Cb/Cr with out_chroma_valid set, otherwise both chroma fields read 128.
//   out_frame_last marks the last pixel of a frame.
//   Frame size is set through cfg_we/cfg_index/cfg_data (index 0: width,
//   index 1: height) while no transaction is in flight.
//   Throughput is one pixel per clock while the receiver takes results.
//   Each odd-column pixel makes one line buffer access (a write on even
//   rows, a read on odd rows), and every pixel passes three register
//   stages: stage 1, stage 2 and the output register.
//   Reset (synchronous, rst_n low) empties the pipeline, puts the raster
//   position at the top-left pixel and restores 640x480. The line buffer is
//   not cleared: an odd row reads only entries the even row above wrote.
//   When the receiver stalls, the result stays on the output and the stages
//   behind it keep filling; in_ready falls only when all three are full.
`default_nettype none

module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH = r2y_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire  [r2y_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire  [r2y_pkg::CFG_W-1:0]     cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [r2y_pkg::PIX_W-1:0]     in_red,
  input  wire  [r2y_pkg::PIX_W-1:0]     in_green,
  input  wire  [r2y_pkg::PIX_W-1:0]     in_blue,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [r2y_pkg::PIX_W-1:0]     out_luma,
  output logic                          out_chroma_valid,
  output logic [r2y_pkg::PIX_W-1:0]     out_chroma_blue,
  output logic [r2y_pkg::PIX_W-1:0]     out_chroma_red,
  output logic                          out_frame_last
);
  import r2y_pkg::*;

  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_W     = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int LINE_SLOTS = (MAX_WIDTH + 1) / 2;

  logic              in_accept;
  logic [ADDR_W-1:0] slot;
  pair_sum_t         pair_sum, s1_sum_r, above;
  pix_ctl_t          ctl;
  logic [LINE_W-1:0] line_rd_data;
  chroma_terms_t     terms;

  logic              s1_valid_r, s1_valid_nxt, s2_valid_r, s2_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load, s2_load, s1_load;
  logic [PIX_W-1:0]  s1_luma_r, s2_luma_r, out_luma_r;
  logic              s1_cv_r, s2_cv_r, out_cv_r;
  logic              s1_last_r, s2_last_r, out_last_r;
  logic [PIX_W-1:0]  out_cb_r, out_cr_r;

  // Stage handshake: each stage loads when it is empty or drains this cycle.
  assign out_load  = !out_valid_r || out_ready;
  assign s2_load   = !s2_valid_r || out_load;
  assign s1_load   = !s1_valid_r || s2_load;
  assign in_ready  = s1_load;
  assign in_accept = in_valid && in_ready;

  // Raster position, size registers and pair sums.
  r2y_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COL_W      (COL_W),
    .ADDR_W     (ADDR_W),
    .LINE_SLOTS (LINE_SLOTS)
  ) u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_accept),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .slot      (slot),
    .pair_sum  (pair_sum),
    .ctl       (ctl)
  );

  // Line buffer: at most one write or one read per accepted pixel, never both.
  r2y_line_buf #(
    .DEPTH  (LINE_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (in_accept && ctl.line_wr),
    .wr_addr   (slot),
    .wr_data   (pair_sum),
    .rd_en     (in_accept && ctl.chroma_valid),
    .rd_addr   (slot),
    .rd_data_r (line_rd_data)
  );

  assign above = pair_sum_t'(line_rd_data);

  // Stage 1: luma and the current pair sums, alongside the line buffer read.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_luma_r <= luma_of(in_red, in_green, in_blue);
      s1_sum_r  <= pair_sum;
      s1_cv_r   <= ctl.chroma_valid;
      s1_last_r <= ctl.frame_last;
    end
  end

  // Stage 2: chroma products.
  r2y_chroma u_chroma (
    .clk     (clk),
    .load    (s2_load && s1_valid_r),
    .above   (above),
    .below   (s1_sum_r),
    .terms_r (terms)
  );

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_luma_r <= s1_luma_r;
      s2_cv_r   <= s1_cv_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Output register: final chroma sums, neutral when no block completes.
  always_ff @(posedge clk) begin
    if (out_load && s2_valid_r) begin
      out_luma_r <= s2_luma_r;
      out_cv_r   <= s2_cv_r;
      out_last_r <= s2_last_r;
      out_cb_r   <= s2_cv_r ? scale_down(terms.pos_b, terms.neg_b, CHROMA_OFFSET)
                            : NEUTRAL_CHROMA;
      out_cr_r   <= s2_cv_r ? scale_down(terms.pos_r, terms.neg_r, CHROMA_OFFSET)
                            : NEUTRAL_CHROMA;
    end
  end

  // Stage valid bits.
  always_comb begin
    s1_valid_nxt  = s1_load  ? in_valid   : s1_valid_r;
    s2_valid_nxt  = s2_load  ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_load ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_cv_r;
  assign out_chroma_blue  = out_cb_r;
  assign out_chroma_red   = out_cr_r;
  assign out_frame_last   = out_last_r;

  // An empty output register never blocks the input.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the output register is empty");

  // The line buffer never sees a write and a read in the same cycle.
  a_single_line_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && ctl.line_wr && ctl.chroma_valid))
    else $error("line buffer write and read in one cycle");

  // Stage 1 fills only from an input transaction.
  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s1_valid_r) |-> $past(in_accept))
    else $error("stage 1 filled without an input transaction");

  // Results without chroma carry neutral chroma.
  a_neutral_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_cv_r) |-> (out_cb_r == NEUTRAL_CHROMA && out_cr_r == NEUTRAL_CHROMA))
    else $error("chroma not neutral on a result without chroma");

endmodule

`default_nettype wire
